// File: src/rs2b_pkg.sv
// shared types, character codes and decode helpers for the radix string converter
package rs2b_pkg;

    // phase of the string scan
    localparam logic [1:0] PH_SPACE   = 2'd0;
    localparam logic [1:0] PH_ZEROS   = 2'd1;
    localparam logic [1:0] PH_DIGITS  = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    // character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] NO_DIGIT   = 8'hff;
    localparam logic [7:0] ALPHA_BIAS = 8'd10;

    // field widths
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 64;
    localparam int IDX_W   = 4;
    localparam int USED_W  = 5;
    localparam int PROD_W  = WORD_W + RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // one step travelling down the cell row
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               mul;
        logic [RADIX_W-1:0] radix;
        logic [RADIX_W-1:0] carry;
    } t_token;

    // value of a digit character, NO_DIGIT for anything else
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = NO_DIGIT;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = c - CHAR_UP_A + ALPHA_BIAS;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = c - CHAR_LO_A + ALPHA_BIAS;
        end
        return d;
    endfunction

    // space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

// File: src/radix_string_to_binary.sv
// top level: character decode, row of accumulator cells and output word buffer
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  input    | i_valid / o_ready            | i_char_code, i_end_of_string
//  output   | o_valid / i_ready            | o_word_value, o_word_index, o_used_words,
//           |                              | o_overflow, o_last_word
//  config   | i_cfg_wr_en                  | i_cfg_wr_data (radix)
//
// one character per cycle while o_ready is high; each cell folds a character in after the
// cell below it, through a step register, the carry between words moving one cell per cycle
// a string's WORDS result beats are loaded into the output buffer when its last character
// leaves the top cell, and leave one per cycle from the buffer while i_ready is high
// the cell row halts only while a finished string sits at the top cell and the buffer
// still holds the previous one; synchronous active-low reset, no clearing pass
module radix_string_to_binary #(
    parameter int WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_word_value,
    output logic [3:0]  o_word_index,
    output logic [4:0]  o_used_words,
    output logic        o_overflow,
    output logic        o_last_word
);
    import rs2b_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

    logic [RADIX_W-1:0] r_radix;
    t_token             front_tok;
    t_token             r_tok [WORDS];
    t_token             n_tok [WORDS];
    logic [WORD_W-1:0]  final_word [WORDS];
    logic               adv;
    logic               top_last;
    logic               buf_free;
    logic               out_beat;
    logic               r_ovf;
    logic               ovf_step;
    logic [USED_W-1:0]  used;

    logic [WORD_W-1:0]  r_buf [WORDS];
    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [USED_W-1:0]  r_used;
    logic               r_bovf;

    // radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_wr_en) begin
            r_radix <= i_cfg_wr_data;
        end
    end

    // row advance control
    assign out_beat = r_busy && i_ready;
    assign buf_free = !r_busy || (out_beat && r_idx == LAST_IDX);
    assign top_last = r_tok[WORDS-1].valid && r_tok[WORDS-1].last;
    assign adv      = !top_last || buf_free;
    assign o_ready  = adv;

    rs2b_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_valid         (i_valid),
        .i_char_code     (i_char_code),
        .i_end_of_string (i_end_of_string),
        .i_radix         (r_radix),
        .o_tok           (front_tok)
    );

    // step registers feeding each cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) begin
                r_tok[i].valid <= 1'b0;
            end
        end else if (adv) begin
            r_tok[0] <= front_tok;
            for (int i = 1; i < WORDS; i++) begin
                r_tok[i] <= n_tok[i-1];
            end
        end
    end

    // cell row
    generate
        for (genvar g = 0; g < WORDS; g++) begin : g_cell
            rs2b_cell #(
                .DEPTH (WORDS - 1 - g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_tok   (r_tok[g]),
                .o_tok   (n_tok[g]),
                .o_final (final_word[g])
            );
        end
    endgenerate

    // carry out of the top word and used word count
    always_comb begin
        ovf_step = r_ovf || (r_tok[WORDS-1].valid && r_tok[WORDS-1].mul
                             && n_tok[WORDS-1].carry != '0);
        used = '0;
        for (int i = 0; i < WORDS; i++) begin
            if (final_word[i] != '0) begin
                used = USED_W'(i + 1);
            end
        end
    end

    // sticky overflow for the string in the top cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (adv && r_tok[WORDS-1].valid) begin
            r_ovf <= r_tok[WORDS-1].last ? 1'b0 : ovf_step;
        end
    end

    // output buffer control, a new run takes over from the final beat of the old one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (adv && top_last) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_beat) begin
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    // output buffer words, shifted down one per beat
    always_ff @(posedge i_clk) begin
        if (adv && top_last) begin
            for (int i = 0; i < WORDS; i++) begin
                r_buf[i] <= final_word[i];
            end
            r_used <= used;
            r_bovf <= ovf_step;
        end else if (out_beat) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_valid      = r_busy;
    assign o_word_value = r_buf[0];
    assign o_word_index = r_idx;
    assign o_used_words = r_used;
    assign o_overflow   = r_bovf;
    assign o_last_word  = (r_idx == LAST_IDX);

endmodule

// File: src/rs2b_front.sv
// character decode and scan phase tracking, produces one step per character
module rs2b_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic [7:0]               i_char_code,
    input  logic                     i_end_of_string,
    input  logic [5:0]               i_radix,
    output rs2b_pkg::t_token         o_tok
);
    import rs2b_pkg::*;

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [7:0] digit;

    // decode the character against the scan phase
    always_comb begin
        digit         = digit_of(i_char_code);
        n_phase       = r_phase;
        o_tok.valid   = i_valid;
        o_tok.last    = i_end_of_string;
        o_tok.mul     = 1'b0;
        o_tok.radix   = i_radix;
        o_tok.carry   = digit[RADIX_W-1:0];
        priority if (r_phase == PH_SPACE && is_space(i_char_code)) begin
            n_phase = PH_SPACE;
        end else if ((r_phase == PH_SPACE || r_phase == PH_ZEROS)
                     && i_char_code == CHAR_ZERO) begin
            n_phase = PH_ZEROS;
        end else if (r_phase != PH_STOPPED) begin
            if (digit >= {2'b00, i_radix}) begin
                n_phase = PH_STOPPED;
            end else begin
                n_phase   = PH_DIGITS;
                o_tok.mul = 1'b1;
            end
        end else begin
            n_phase = PH_STOPPED;
        end
        if (i_end_of_string) begin
            n_phase = PH_SPACE;
        end
    end

    // phase register, moves on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
        end else if (i_valid && i_adv) begin
            r_phase <= n_phase;
        end
    end

endmodule

// File: src/rs2b_cell.sv
// one accumulator word: multiply by radix plus carry, and a delay line for the final word
module rs2b_cell #(
    parameter int DEPTH = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  rs2b_pkg::t_token         i_tok,
    output rs2b_pkg::t_token         o_tok,
    output logic [63:0]              o_final
);
    import rs2b_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [PROD_W-1:0] prod;

    // word times radix plus incoming carry
    always_comb begin
        prod   = PROD_W'(r_word) * PROD_W'(i_tok.radix) + PROD_W'(i_tok.carry);
        n_word = (i_tok.valid && i_tok.mul) ? prod[WORD_W-1:0] : r_word;
        o_tok  = i_tok;
        o_tok.carry = (i_tok.valid && i_tok.mul) ? prod[PROD_W-1:WORD_W] : '0;
    end

    // word register, cleared once the string ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_adv) begin
            r_word <= (i_tok.valid && i_tok.last) ? '0 : n_word;
        end
    end

    // line up the final word with the top cell's last step
    generate
        if (DEPTH == 0) begin : g_direct
            assign o_final = n_word;
        end else begin : g_delay
            logic [WORD_W-1:0] r_dly [DEPTH];
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_dly[0] <= n_word;
                    for (int k = 1; k < DEPTH; k++) begin
                        r_dly[k] <= r_dly[k-1];
                    end
                end
            end
            assign o_final = r_dly[DEPTH-1];
        end
    endgenerate

endmodule

// File: src/rs2b_check.sv
// port-level checks on the converter's result beats
module rs2b_check #(
    parameter int WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [3:0]  o_word_index,
    input  logic [4:0]  o_used_words,
    input  logic        o_overflow,
    input  logic        o_last_word
);

    localparam logic [3:0] LAST_IDX  = 4'(WORDS - 1);
    localparam logic [4:0] USED_MAX  = 5'(WORDS);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // words of a run follow in order with one count and one overflow flag
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=>
            o_valid && o_word_index == $past(o_word_index) + 4'd1
            && $stable(o_used_words) && $stable(o_overflow))
        else $error("result run broken");

    // a new run starts at word zero
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_word |=> !o_valid || o_word_index == 4'd0)
        else $error("result run does not start at word zero");

    // last flag marks exactly the top word
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == LAST_IDX)))
        else $error("last word flag mismatch");

    // used count never exceeds the accumulator size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_used_words <= USED_MAX)
        else $error("used word count out of range");

endmodule

bind radix_string_to_binary rs2b_check #(.WORDS(WORDS)) u_rs2b_check (.*);
